### hdl/xse_pkg.sv
// Shared constants for the exchange sort engine.
package xse_pkg;

    // Width of the value field on both channels.
    localparam int FIELD_BITS = 16;

    // Width of the swap count reported with every result.
    localparam int SWAP_BITS = 11;

    // Swap count as carried through the design.
    typedef logic [SWAP_BITS-1:0] swap_count_t;

endpackage

### hdl/xse_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module xse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/exchange_sort_engine_core.sv
// Exchange sort engine: loads a set of values, sorts it in a RAM and streams it out in order.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------
//  load     | load_valid / load_stall    | value[15:0], last
//  result   | result_valid / result_stall| sorted_value[15:0], swap_total[10:0],
//           |                            | final_res
//
//  A set of values (ended by last or a full store) is then sorted with one compare per cycle
//  on the RAM read port, plus a head fetch and a head write-back for each outer position.
//  Each result is a RAM read followed by an output register load.
//  Reset clears all control state; every RAM entry is written in a set before it is read.
//  load_stall is high from the end of a set until its last result is in the output
//  register; result_stall holds the output register and pauses emission.
module exchange_sort_engine_core
    import xse_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_stall,
    input  logic [FIELD_BITS-1:0] value,
    input  logic                  last,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [FIELD_BITS-1:0] sorted_value,
    output logic [SWAP_BITS-1:0]  swap_total,
    output logic                  final_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int VW = VALUE_BITS;

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_FETCH   = 3'd1;
    localparam logic [2:0] ST_HEAD    = 3'd2;
    localparam logic [2:0] ST_INNER   = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_LD = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [AW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [AW-1:0]         k_reg, k_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [VW-1:0]         cur_reg, cur_next;
    swap_count_t           swap_reg, swap_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_value_reg;
    swap_count_t           out_swap_reg;
    logic                  out_final_reg;

    logic                  load_take;
    logic                  emit_take;
    logic                  emit_final;
    logic [CW-1:0]         fill_inc;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VW-1:0]         wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [VW-1:0]         rd_data;

    // Value store.
    xse_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake terms.
    assign load_stall = (state_reg != ST_LOAD);
    assign load_take  = load_valid && !load_stall;
    assign emit_take  = (state_reg == ST_EMIT_LD) && (!out_valid_reg || !result_stall);
    assign emit_final = ((CW'(k_reg) + CW'(1)) == n_reg);
    assign fill_inc   = fill_reg + CW'(1);

    // Sequencer: load, outer fetch, inner compare-swap stream, emission.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cur_next       = cur_reg;
        swap_next      = swap_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[AW-1:0];
        wr_data        = VW'(value);
        rd_en          = 1'b0;
        rd_addr        = i_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_take)
                begin
                    wr_en = 1'b1;
                    if (last || (fill_inc == CW'(MAX_ITEMS)))
                    begin
                        // The set is complete; a single value needs no sort.
                        n_next    = fill_inc;
                        fill_next = '0;
                        swap_next = '0;
                        i_next    = '0;
                        k_next    = '0;
                        if (fill_reg == '0)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end

            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                j_next     = CW'(i_reg) + CW'(1);
                state_next = ST_HEAD;
            end

            ST_HEAD:
            begin
                cur_next   = rd_data;
                pend_next  = 1'b0;
                state_next = ST_INNER;
            end

            ST_INNER:
            begin
                // Compare the entry read last cycle against the running head value.
                if (pend_reg && (cur_reg > rd_data))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = pend_addr_reg;
                    wr_data   = cur_reg;
                    cur_next  = rd_data;
                    swap_next = swap_reg + SWAP_BITS'(1);
                end
                // Issue the next read, or write the head back once the pass drains.
                if (j_reg < n_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = j_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = j_reg[AW-1:0];
                    j_next         = j_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = i_reg;
                        wr_data = cur_reg;
                        if ((CW'(i_reg) + CW'(2)) == n_reg)
                        begin
                            k_next     = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            i_next     = i_reg + AW'(1);
                            state_next = ST_FETCH;
                        end
                    end
                end
            end

            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (emit_take)
                begin
                    k_next = k_reg + AW'(1);
                    if (emit_final)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            swap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            swap_reg      <= swap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit_take)
        begin
            out_value_reg <= FIELD_BITS'(rd_data);
            out_swap_reg  <= swap_reg;
            out_final_reg <= emit_final;
        end
    end

    assign result_valid = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign swap_total   = out_swap_reg;
    assign final_res    = out_final_reg;

    // The streamed entry always lies after the head position.
    a_pend_after_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INNER && pend_reg) |-> (pend_addr_reg > i_reg))
        else $error("inner pass touches the head entry");

    // The inner index never runs past the set.
    a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INNER) |-> (j_reg <= n_reg))
        else $error("inner index beyond set size");

    // Taking the final result returns the block to loading.
    a_final_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_take && emit_final) |=> (state_reg == ST_LOAD))
        else $error("final result did not end the set");

    // The fill count stays below the store depth while loading.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (fill_reg < CW'(MAX_ITEMS)))
        else $error("fill count reached store depth");

endmodule

### tb/exchange_sort_engine_core_tb.sv
// Self-checking testbench for the exchange sort engine core.
module exchange_sort_engine_core_tb
    import xse_pkg::*;
;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 300;
    localparam logic [FIELD_BITS-1:0] VALUE_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - VALUE_BITS);

    // One sorted value as it should leave the result channel.
    typedef struct packed {
        logic [FIELD_BITS-1:0] val;
        swap_count_t           swaps;
        logic                  fin;
    } sorted_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  load_valid;
    logic                  load_stall;
    logic [FIELD_BITS-1:0] value;
    logic                  last;
    logic                  result_valid;
    logic                  result_stall;
    logic [FIELD_BITS-1:0] sorted_value;
    logic [SWAP_BITS-1:0]  swap_total;
    logic                  final_res;

    // Values of the set being loaded, and the sorted values still to arrive.
    logic [FIELD_BITS-1:0] loaded_values[$];
    sorted_item_t          expected_sorted[$];

    int error_count;
    int cycle_count;
    int load_idle_pct;
    int result_stall_pct;
    bit full_set_last;

    exchange_sort_engine_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_stall   (load_stall),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sorted_value (sorted_value),
        .swap_total   (swap_total),
        .final_res    (final_res)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that hangs ends here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sort the loaded set the way the engine does and queue its results.
    task automatic predict_sorted_set();
        logic [FIELD_BITS-1:0] work[MAX_ITEMS];
        logic [FIELD_BITS-1:0] held;
        swap_count_t           swaps;
        sorted_item_t          item;
        int                    n;
        n = loaded_values.size();
        swaps = '0;
        for (int k = 0; k < n; k++)
        begin
            work[k] = loaded_values[k];
        end
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j < n; j++)
            begin
                if (work[i] > work[j])
                begin
                    held    = work[i];
                    work[i] = work[j];
                    work[j] = held;
                    swaps++;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            item.val   = work[k];
            item.swaps = swaps;
            item.fin   = (k == n - 1);
            expected_sorted.push_back(item);
        end
        loaded_values.delete();
    endtask

    // Send one value; valid stays high afterwards unless the next call idles first.
    task automatic send_value(input logic [FIELD_BITS-1:0] v, input logic l);
        while ($urandom_range(99) < load_idle_pct)
        begin
            load_valid <= 1'b0;
            @(posedge clk);
        end
        load_valid <= 1'b1;
        value      <= v;
        last       <= l;
        @(posedge clk);
        while (load_stall)
        begin
            @(posedge clk);
        end
        // The transfer happened at this edge; update the prediction.
        loaded_values.push_back(v & VALUE_MASK);
        if (l || loaded_values.size() == MAX_ITEMS)
        begin
            predict_sorted_set();
        end
    endtask

    // Send a whole set with the last flag on its final value.
    task automatic send_set(input logic [FIELD_BITS-1:0] vals[$]);
        foreach (vals[k])
        begin
            send_value(vals[k], k == vals.size() - 1);
        end
    endtask

    // Hold off the load channel until every expected result has come.
    task automatic wait_results_drained();
        load_valid <= 1'b0;
        @(posedge clk);
        while (expected_sorted.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result channel: random stall, and every transfer checked in order.
    always @(posedge clk)
    begin
        sorted_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_sorted.size() == 0)
            begin
                $display("%0t: unexpected result value=%h swaps=%0d final=%b",
                         $time, sorted_value, swap_total, final_res);
                error_count++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (sorted_value !== want.val || swap_total !== want.swaps ||
                    final_res !== want.fin)
                begin
                    $display("%0t: mismatch expected value=%h swaps=%0d final=%b, actual value=%h swaps=%0d final=%b",
                             $time, want.val, want.swaps, want.fin,
                             sorted_value, swap_total, final_res);
                    error_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Extremes, bit patterns, ties, one-value sets and a fully reversed set.
    task automatic test_directed();
        send_set('{16'h0000});
        send_set('{16'hFFFF});
        send_set('{16'hFFFF, 16'h0000});
        send_set('{16'h0000, 16'hFFFF});
        send_set('{16'h0007, 16'h0007, 16'h0007});
        send_set('{16'h5555, 16'hAAAA, 16'h8000, 16'h0001, 16'h7FFF});
        send_set('{16'h0005, 16'h0004, 16'h0003, 16'h0002, 16'h0001});
    endtask

    // A set that ends only because the store fills, without a last flag.
    task automatic test_store_full();
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            send_value(16'($urandom), 1'b0);
        end
    endtask

    // Random sets: mostly small, some large, some filling the store.
    task automatic test_random_sets(input int n_items);
        int                    sent;
        int                    size;
        int                    pick;
        int                    shape;
        int                    step;
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] v;
        logic                  l;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                size = MAX_ITEMS;
            end
            else if (pick < 20)
            begin
                size = $urandom_range(13, MAX_ITEMS - 1);
            end
            else
            begin
                size = $urandom_range(1, 12);
            end
            // Full sets alternate between an explicit last flag and none.
            if (size == MAX_ITEMS)
            begin
                full_set_last = ~full_set_last;
            end
            shape = $urandom_range(3);
            base  = 16'($urandom);
            step  = $urandom_range(1, 300);
            for (int k = 0; k < size; k++)
            begin
                case (shape)
                    0: v = 16'($urandom);
                    1: v = 16'($urandom_range(7));
                    2: v = base + 16'(k * step);
                    default: v = base - 16'(k * step);
                endcase
                if (k == size - 1)
                begin
                    l = (size == MAX_ITEMS) ? full_set_last : 1'b1;
                end
                else
                begin
                    l = 1'b0;
                end
                send_value(v, l);
            end
            sent += size;
        end
    endtask

    // Test sequence.
    initial
    begin
        error_count      = 0;
        full_set_last    = 1'b0;
        load_idle_pct    = 31;
        result_stall_pct = 81;
        rst_n        <= 1'b0;
        load_valid   <= 1'b0;
        value        <= '0;
        last         <= 1'b0;
        result_stall <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_store_full();
        test_random_sets(135);
        wait_results_drained();

        load_idle_pct    = 81;
        result_stall_pct = 31;
        test_random_sets(135);
        wait_results_drained();

        load_idle_pct    = 0;
        result_stall_pct = 0;
        test_random_sets(135);
        wait_results_drained();

        // Let any stray results show before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_sorted.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_sorted.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/xse_pkg.sv
hdl/xse_ram.sv
hdl/exchange_sort_engine_core.sv
tb/exchange_sort_engine_core_tb.sv
